// File: sv/aabb_collision_resolver_assert.svh
// assertion macros shared by the resolver rtl
// expects clk and arst_n in the scope of use
`ifndef AABB_COLLISION_RESOLVER_ASSERT_SVH
`define AABB_COLLISION_RESOLVER_ASSERT_SVH

// same-cycle implication
`define AABB_ASSERT_IMP(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("aabb check failed: pre |-> post");

// next-cycle implication
`define AABB_ASSERT_NXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("aabb check failed: pre |=> post");

`endif

// File: sv/aabb_pkg.sv
// shared types and constants of the box pair resolver
// no dependencies
package aabb_pkg;

	localparam int COMPONENT_WIDTH = 32;
	localparam int FRAC_BITS       = 16;

	typedef enum logic [1:0] {
		OP_QUERY = 2'd0,
		OP_DYN   = 2'd1,
		OP_STAT  = 2'd2,
		OP_SPARE = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [63:0] b1_pos;
		logic [63:0] b1_size;
		logic [63:0] b1_vel;
		logic [63:0] b2_pos;
		logic [63:0] b2_size;
		logic [63:0] b2_vel;
	} item_t;

endpackage

// File: sv/aabb_pair_if.sv
// request channel of the resolver: one box pair and an operation
// depends on nothing
interface aabb_pair_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [63:0] b1_pos;
	logic [63:0] b1_size;
	logic [63:0] b1_vel;
	logic [63:0] b2_pos;
	logic [63:0] b2_size;
	logic [63:0] b2_vel;

	modport source (output valid, op, b1_pos, b1_size, b1_vel, b2_pos, b2_size, b2_vel,
		input ready);
	modport sink (input valid, op, b1_pos, b1_size, b1_vel, b2_pos, b2_size, b2_vel,
		output ready);
endinterface

// File: sv/aabb_result_if.sv
// result channel of the resolver: penetrations and updated bodies
// depends on nothing
interface aabb_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pen_x;
	logic signed [31:0] pen_y;
	logic               colliding;
	logic               axis_used;
	logic [63:0]        new_b1_pos;
	logic [63:0]        new_b1_vel;
	logic [63:0]        new_b2_pos;
	logic [63:0]        new_b2_vel;

	modport source (output valid, pen_x, pen_y, colliding, axis_used, new_b1_pos,
		new_b1_vel, new_b2_pos, new_b2_vel, input ready);
	modport sink (input valid, pen_x, pen_y, colliding, axis_used, new_b1_pos,
		new_b1_vel, new_b2_pos, new_b2_vel, output ready);
endinterface

// File: sv/aabb_collision_resolver.sv
// box pair collision resolver, minimum penetration, fixed point
// uses aabb_pkg, aabb_pair_if, aabb_result_if and the assertion macros
//
// channel  | role | carries
// pair     | sink | op, two boxes (pos, size, vel)
// result   | src  | penetrations, collide flag, axis, updated boxes
//
// one request per cycle unless a held result stalls the input; the ratio divider
// produces one quotient bit per divider stage
// reset clears only the stage valid bits; the datapath needs none
// a held result stalls every stage and the input with it
module aabb_collision_resolver import aabb_pkg::*; #(
	parameter int COMPONENT_WIDTH = aabb_pkg::COMPONENT_WIDTH,
	parameter int FRAC_BITS       = aabb_pkg::FRAC_BITS
) (
	input logic          clk,
	input logic          arst_n,
	aabb_pair_if.sink    pair,
	aabb_result_if.source result
);

	localparam int W    = COMPONENT_WIDTH;
	localparam int F    = FRAC_BITS;
	localparam int DS   = W + F;
	localparam int RW   = (F + 1 > W) ? F + 1 : W;
	localparam int PW   = W + RW + 1;
	localparam int SATW = PW + 2;

	localparam logic signed [SATW-1:0] CMAX_X = (SATW'(1) <<< (W - 1)) - SATW'(1);
	localparam logic signed [SATW-1:0] CMIN_X = -(SATW'(1) <<< (W - 1));
	localparam logic [DS-1:0] QMAX = (DS'(1) << (W - 1)) - DS'(1);
	localparam logic [DS-1:0] QLIM = DS'(1) << (W - 1);
	localparam logic signed [RW:0] QONE_R = (RW + 1)'(1) <<< F;

	typedef struct packed {
		item_t                item;
		logic signed [W-1:0]  penx;
		logic signed [W-1:0]  peny;
		logic signed [W-1:0]  s1a;
		logic signed [W-1:0]  s2a;
		logic signed [W-1:0]  a;
		logic signed [W-1:0]  b;
		logic signed [W-1:0]  statp;
		logic signed [W:0]    vsum;
		logic                 ax;
		logic                 lt;
		logic                 vzero;
	} side_t;

	function automatic logic signed [W-1:0] comp(input logic [63:0] x, input logic up);
		logic [31:0] h;
		h = up ? x[63:32] : x[31:0];
		return h[W-1:0];
	endfunction

	function automatic logic [31:0] ext32(input logic signed [W-1:0] v);
		return 32'(v);
	endfunction

	function automatic logic signed [W-1:0] sat(input logic signed [SATW-1:0] v);
		if (v > CMAX_X)
			return CMAX_X[W-1:0];
		if (v < CMIN_X)
			return CMIN_X[W-1:0];
		return v[W-1:0];
	endfunction

	logic en;
	assign en = !result.valid || result.ready;
	assign pair.ready = en;

	// ---------------- stage 1: penetration per axis
	item_t               itm;
	logic signed [W-1:0] p1x, p1y, s1x, s1y, p2x, p2y, s2x, s2y;
	logic signed [SATW-1:0] rx, ry;
	logic signed [W-1:0] penx, peny;

	always_comb begin
		itm = '{op: pair.op, b1_pos: pair.b1_pos, b1_size: pair.b1_size,
			b1_vel: pair.b1_vel, b2_pos: pair.b2_pos, b2_size: pair.b2_size,
			b2_vel: pair.b2_vel};
		p1x = comp(itm.b1_pos, 1'b1);  p1y = comp(itm.b1_pos, 1'b0);
		s1x = comp(itm.b1_size, 1'b1); s1y = comp(itm.b1_size, 1'b0);
		p2x = comp(itm.b2_pos, 1'b1);  p2y = comp(itm.b2_pos, 1'b0);
		s2x = comp(itm.b2_size, 1'b1); s2y = comp(itm.b2_size, 1'b0);
		rx = (p1x < p2x) ? SATW'(p2x) - SATW'(p1x) - SATW'(s1x)
			: SATW'(p1x) - SATW'(p2x) - SATW'(s2x);
		ry = (p1y < p2y) ? SATW'(p2y) - SATW'(p1y) - SATW'(s1y)
			: SATW'(p1y) - SATW'(p2y) - SATW'(s2y);
		penx = (rx < 0) ? sat(rx) : '0;
		peny = (ry < 0) ? sat(ry) : '0;
	end

	logic                vld_s1;
	item_t               item_s1;
	logic signed [W-1:0] penx_s1, peny_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= pair.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= itm;
			penx_s1 <= penx;
			peny_s1 <= peny;
		end
	end

	// ---------------- stage 2: axis choice, operand setup
	logic signed [W-1:0] p1, s1, v1, p2, s2, v2;
	logic                sel, is_res;
	side_t               sd0;
	logic [W-1:0]        abs_v1;
	logic [W:0]          abs_vs;

	always_comb begin
		// ties go to y
		sel = !(penx_s1 > peny_s1);
		is_res = (item_s1.op == OP_DYN) || (item_s1.op == OP_STAT);
		p1 = comp(item_s1.b1_pos, !sel);
		s1 = comp(item_s1.b1_size, !sel);
		v1 = comp(item_s1.b1_vel, !sel);
		p2 = comp(item_s1.b2_pos, !sel);
		s2 = comp(item_s1.b2_size, !sel);
		v2 = comp(item_s1.b2_vel, !sel);

		sd0.item  = item_s1;
		sd0.penx  = penx_s1;
		sd0.peny  = peny_s1;
		sd0.ax    = is_res & sel;
		sd0.lt    = p1 < p2;
		sd0.s1a   = s1;
		sd0.s2a   = s2;
		sd0.a     = sd0.lt ? sat(SATW'(p1) + SATW'(s1)) : p1;
		sd0.b     = sd0.lt ? p2 : sat(SATW'(p2) + SATW'(s2));
		sd0.statp = sd0.lt ? sat(SATW'(p2) - SATW'(s1)) : sat(SATW'(p2) + SATW'(s2));
		sd0.vsum  = (W + 1)'(v1) + (W + 1)'(v2);
		sd0.vzero = sd0.vsum == '0;
		abs_v1 = v1[W-1] ? (~v1 + W'(1)) : v1;
		abs_vs = sd0.vsum[W] ? (~sd0.vsum + (W + 1)'(1)) : sd0.vsum;
	end

	// ---------------- divider stages, one quotient bit each
	logic           vld_sd [0:DS];
	side_t          side_sd[0:DS];
	logic [DS-1:0]  num_sd [0:DS];
	logic [W:0]     den_sd [0:DS];
	logic [W:0]     rem_sd [0:DS];
	logic [DS-1:0]  q_sd   [0:DS];
	logic           neg_sd [0:DS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sd[0] <= 1'b0;
		end else if (en) begin
			vld_sd[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_sd[0] <= sd0;
			num_sd[0]  <= DS'(abs_v1) << F;
			den_sd[0]  <= abs_vs;
			rem_sd[0]  <= '0;
			q_sd[0]    <= '0;
			neg_sd[0]  <= v1[W-1] ^ sd0.vsum[W];
		end
	end

	for (genvar k = 0; k < DS; k++) begin : g_div
		logic [W+1:0] trial;
		logic         take;
		assign trial = {rem_sd[k], num_sd[k][DS-1]};
		assign take  = trial >= {1'b0, den_sd[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sd[k+1] <= 1'b0;
			end else if (en) begin
				vld_sd[k+1] <= vld_sd[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_sd[k+1] <= side_sd[k];
				num_sd[k+1]  <= num_sd[k] << 1;
				den_sd[k+1]  <= den_sd[k];
				rem_sd[k+1]  <= take ? (W + 1)'(trial - {1'b0, den_sd[k]}) : trial[W:0];
				q_sd[k+1]    <= {q_sd[k][DS-2:0], take};
				neg_sd[k+1]  <= neg_sd[k];
			end
		end
	end

	// ---------------- ratio sign and saturation
	logic signed [RW-1:0] ratio;
	logic [DS-1:0]        qmag;

	always_comb begin
		qmag = q_sd[DS];
		if (side_sd[DS].vzero)
			ratio = RW'(1) <<< (F - 1);
		else if (neg_sd[DS])
			ratio = (qmag > QLIM) ? RW'(CMIN_X) : -RW'(qmag);
		else
			ratio = (qmag > QMAX) ? RW'(CMAX_X) : RW'(qmag);
	end

	logic                 vld_sr;
	side_t                side_sr;
	logic signed [RW-1:0] ratio_sr;
	logic signed [RW:0]   omr_sr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sr <= 1'b0;
		end else if (en) begin
			vld_sr <= vld_sd[DS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_sr  <= side_sd[DS];
			ratio_sr <= ratio;
			omr_sr   <= QONE_R - (RW + 1)'(ratio);
		end
	end

	// ---------------- weighted products
	logic signed [PW-1:0] pa, pb;

	always_comb begin
		pa  = PW'(side_sr.a) * PW'(ratio_sr);
		pb  = PW'(side_sr.b) * PW'(omr_sr);
	end

	logic                 vld_sm;
	side_t                side_sm;
	logic signed [PW-1:0] pa_sm, pb_sm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sm <= 1'b0;
		end else if (en) begin
			vld_sm <= vld_sr;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_sm <= side_sr;
			pa_sm   <= pa;
			pb_sm   <= pb;
		end
	end

	// ---------------- centre, new positions, output assembly
	logic signed [SATW-1:0] csum;
	logic signed [W-1:0]    center, np1, np2, avg;
	logic signed [W-1:0]    o_p1[2], o_v1[2], o_p2[2], o_v2[2];
	item_t                  oi;

	always_comb begin
		oi = side_sm.item;
		// arithmetic shift gives the floor
		csum   = SATW'(pa_sm >>> F) + SATW'(pb_sm >>> F);
		center = sat(csum);
		np1    = side_sm.lt ? sat(SATW'(center) - SATW'(side_sm.s1a)) : center;
		np2    = side_sm.lt ? center : sat(SATW'(center) - SATW'(side_sm.s2a));
		avg    = W'(side_sm.vsum >>> 1);
		o_p1[0] = comp(oi.b1_pos, 1'b1); o_p1[1] = comp(oi.b1_pos, 1'b0);
		o_v1[0] = comp(oi.b1_vel, 1'b1); o_v1[1] = comp(oi.b1_vel, 1'b0);
		o_p2[0] = comp(oi.b2_pos, 1'b1); o_p2[1] = comp(oi.b2_pos, 1'b0);
		o_v2[0] = comp(oi.b2_vel, 1'b1); o_v2[1] = comp(oi.b2_vel, 1'b0);
		case (oi.op)
			OP_DYN: begin
				o_p1[side_sm.ax] = np1;
				o_v1[side_sm.ax] = avg;
				o_p2[side_sm.ax] = np2;
				o_v2[side_sm.ax] = avg;
			end
			OP_STAT: begin
				o_p1[side_sm.ax] = side_sm.statp;
				o_v1[side_sm.ax] = '0;
			end
			default: begin
			end
		endcase
	end

	logic vld_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out_q <= 1'b0;
		end else if (en) begin
			vld_out_q <= vld_sm;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result.pen_x      <= 32'(side_sm.penx);
			result.pen_y      <= 32'(side_sm.peny);
			result.colliding  <= (side_sm.penx != '0) && (side_sm.peny != '0);
			result.axis_used  <= side_sm.ax;
			result.new_b1_pos <= {ext32(o_p1[0]), ext32(o_p1[1])};
			result.new_b1_vel <= {ext32(o_v1[0]), ext32(o_v1[1])};
			result.new_b2_pos <= {ext32(o_p2[0]), ext32(o_p2[1])};
			result.new_b2_vel <= {ext32(o_v2[0]), ext32(o_v2[1])};
		end
	end

	assign result.valid = vld_out_q;

	`include "aabb_collision_resolver_assert.svh"

	`AABB_ASSERT_IMP(a_pen_nonpos, result.valid, (result.pen_x <= 0) && (result.pen_y <= 0))
	`AABB_ASSERT_IMP(a_rem_below_den, vld_sd[DS] && !side_sd[DS].vzero, rem_sd[DS] < den_sd[DS])
	`AABB_ASSERT_NXT(a_stall_holds, result.valid && !result.ready, $stable(q_sd[DS]) && $stable(vld_sm))

endmodule
